// ===== rtl/tmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Trapezoid motion profile package
// Shared payload types, register indexes, sequencer states and unit controls.
// ----------------------------------------------------------------------------
package tmp_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int RW = 31;

    localparam logic [1:0] CFG_VEL_LIMIT = 2'd0;
    localparam logic [1:0] CFG_ACC_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TICK      = 2'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic                 op;
        logic signed [DW-1:0] goal_position;
        logic signed [DW-1:0] present_position;
    } tmp_in_t;

    typedef struct packed {
        logic signed [DW-1:0] position_setpoint;
        logic signed [DW-1:0] velocity_setpoint;
        logic signed [DW-1:0] accel_setpoint;
        logic                 profile_done;
    } tmp_out_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SETUP, ST_MUL_VV, ST_MUL_DA, ST_CMP, ST_DIV1, ST_SQRT,
        ST_MUL_PK, ST_PEAK, ST_DIV2, ST_DIV3, ST_PHASE, ST_MA, ST_MB, ST_MC,
        ST_MD, ST_ME, ST_MF, ST_COMB, ST_OUT
    } tmp_state_t;

    typedef enum logic [1:0] {
        PH_ACCEL, PH_CRUISE, PH_DECEL, PH_DONE
    } tmp_phase_t;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } tmp_iter_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tmp_iter_stat_t;

endpackage

// ===== rtl/tmp_mul.sv =====
// ----------------------------------------------------------------------------
// Trapezoid motion profile multiplier
// Unsigned 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module tmp_mul (
    input  logic                     aclk,
    input  logic [tmp_pkg::DW-1:0]   a,
    input  logic [tmp_pkg::DW-1:0]   b,
    output logic [2*tmp_pkg::DW-1:0] prod
);

    logic [2*tmp_pkg::DW-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/tmp_iter.sv =====
// ----------------------------------------------------------------------------
// Trapezoid motion profile divide and root unit
// Restoring divider (one quotient bit per cycle) and integer square root
// (one root bit per cycle) sharing one remainder register and subtractor.
// ----------------------------------------------------------------------------
module tmp_iter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tmp_pkg::tmp_iter_ctrl_t    ctrl,
    input  logic [2*tmp_pkg::DW-1:0]   dividend,
    input  logic [tmp_pkg::DW-1:0]     divisor,
    output tmp_pkg::tmp_iter_stat_t    stat,
    output logic [2*tmp_pkg::DW-1:0]   result
);

    logic [6:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic        mode_reg;
    logic [63:0] n_reg, q_reg;
    logic [34:0] rem_reg;
    logic [31:0] d_reg;
    logic [34:0] rem_sh, trial, diff;
    logic        ge;

    always_comb begin
        if (mode_reg) begin
            rem_sh = {rem_reg[32:0], n_reg[63:62]};
            trial  = {1'b0, q_reg[31:0], 2'b01};
        end else begin
            rem_sh = {rem_reg[33:0], n_reg[63]};
            trial  = {3'b000, d_reg};
        end
        ge   = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            cnt_next = ctrl.sqrt_mode ? 7'd32 : 7'd64;
        end else if (cnt_reg != 7'd0) begin
            cnt_next  = cnt_reg - 7'd1;
            done_next = (cnt_reg == 7'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            mode_reg <= ctrl.sqrt_mode;
            n_reg    <= dividend;
            d_reg    <= divisor;
            q_reg    <= 64'd0;
            rem_reg  <= 35'd0;
        end else if (cnt_reg != 7'd0) begin
            n_reg   <= mode_reg ? {n_reg[61:0], 2'b00} : {n_reg[62:0], 1'b0};
            q_reg   <= {q_reg[62:0], ge};
            rem_reg <= ge ? diff : rem_sh;
        end
    end

    assign stat.busy = (cnt_reg != 7'd0);
    assign stat.done = done_reg;
    assign result    = q_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> cnt_reg == 7'd0)
        else $error("unit restarted while busy");

    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 7'd1 && !ctrl.start |=> done_reg && cnt_reg == 7'd0)
        else $error("done did not follow the last step");

endmodule

// ===== rtl/trapezoid_motion_profile.sv =====
// ----------------------------------------------------------------------------
// Trapezoid motion profile
// One-axis trapezoidal or triangular motion profile generator in Q16.16.
// ----------------------------------------------------------------------------
// A start transaction latches the move and computes ramp and cruise times
// with a bit-serial divider and square root unit, then returns the sample at
// time zero; a trapezoid takes three quotients and a triangle one quotient
// and a root. A tick transaction issues five products in turn to one shared
// registered multiplier. The input is not ready while an item is in work; a
// finished result waits in an output register while the next transaction is
// taken. Configuration writes are taken at any time and apply to stored times
// at the next start.
module trapezoid_motion_profile (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tmp_pkg::tmp_in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output tmp_pkg::tmp_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    tmp_pkg::tmp_state_t state_reg, state_next;

    logic [30:0] vel_lim_reg, acc_lim_reg, tick_reg;
    logic [30:0] vl_nz, al_nz;

    tmp_pkg::tmp_in_t  in_reg;
    tmp_pkg::tmp_out_t out_reg;
    logic              m_valid_reg;

    logic signed [31:0] start_point_reg;
    logic [31:0] dist_reg, ramp_reg, cruise_reg, peak_reg, elapsed_reg;
    logic        down_reg, tri_reg, done_flag_reg;
    logic [63:0] vv_reg;
    logic [31:0] dist_rem_reg;
    tmp_pkg::tmp_phase_t phase_reg;
    logic [31:0] x_reg, y_reg, vel_reg, pos_reg, spd_reg;
    logic [46:0] term0_reg, s_reg;
    logic [47:0] term1_reg, term2_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;
    tmp_pkg::tmp_iter_ctrl_t iter_ctrl;
    tmp_pkg::tmp_iter_stat_t iter_stat;
    logic [63:0] iter_dividend, iter_result;
    logic [31:0] iter_divisor;

    logic signed [32:0] delta;
    logic [32:0] mag;
    logic        tri_now;
    logic [32:0] rc_sum;
    logic [33:0] total;
    logic [31:0] t_dec, e_r;
    logic [49:0] p_sum, p_raw;
    logic [31:0] p_fin, v_fin;
    logic [31:0] vel_min;
    logic signed [33:0] pos_ext;
    logic signed [32:0] vel_ext;
    logic signed [31:0] acc_val;
    logic [32:0] el_sum;

    assign vl_nz = (vel_lim_reg == 31'd0) ? 31'd1 : vel_lim_reg;
    assign al_nz = (acc_lim_reg == 31'd0) ? 31'd1 : acc_lim_reg;

    assign s_ready   = (state_reg == tmp_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    tmp_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    tmp_iter u_iter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (iter_ctrl),
        .dividend (iter_dividend),
        .divisor  (iter_divisor),
        .stat     (iter_stat),
        .result   (iter_result)
    );

    always_comb begin
        delta   = {in_reg.goal_position[31], in_reg.goal_position}
                - {in_reg.present_position[31], in_reg.present_position};
        mag     = delta[32] ? 33'(-delta) : 33'(delta);
        tri_now = (vv_reg > mul_prod);
        rc_sum  = {1'b0, ramp_reg} + {1'b0, cruise_reg};
        total   = {1'b0, ramp_reg, 1'b0} + {2'b00, cruise_reg};
        t_dec   = elapsed_reg - ramp_reg - cruise_reg;
        e_r     = elapsed_reg - ramp_reg;
        vel_min = (mul_prod[63:16] > {16'd0, peak_reg}) ? peak_reg : mul_prod[47:16];
        el_sum  = {1'b0, elapsed_reg} + {2'b00, tick_reg};
    end

    always_comb begin
        p_sum = {3'b000, term0_reg} + {2'b00, term1_reg} + {2'b00, term2_reg};
        case (phase_reg)
            tmp_pkg::PH_ACCEL: begin
                p_raw = {3'b000, s_reg};
                v_fin = vel_reg;
            end
            tmp_pkg::PH_CRUISE: begin
                p_raw = {3'b000, term0_reg} + {2'b00, term2_reg};
                v_fin = peak_reg;
            end
            tmp_pkg::PH_DECEL: begin
                p_raw = (p_sum > {3'b000, s_reg}) ? p_sum - {3'b000, s_reg} : 50'd0;
                v_fin = peak_reg - vel_reg;
            end
            default: begin
                p_raw = {18'd0, dist_reg};
                v_fin = 32'd0;
            end
        endcase
        p_fin = (p_raw > {18'd0, dist_reg}) ? dist_reg : p_raw[31:0];
    end

    always_comb begin
        pos_ext = down_reg ? 34'(start_point_reg) - $signed({2'b00, pos_reg})
                           : 34'(start_point_reg) + $signed({2'b00, pos_reg});
        vel_ext = down_reg ? -$signed({1'b0, spd_reg}) : $signed({1'b0, spd_reg});
        case (phase_reg)
            tmp_pkg::PH_ACCEL: acc_val = $signed({1'b0, al_nz});
            tmp_pkg::PH_DECEL: acc_val = -$signed({1'b0, al_nz});
            default:           acc_val = 32'sd0;
        endcase
        if (down_reg) begin
            acc_val = -acc_val;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tmp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.op == tmp_pkg::OP_START) ? tmp_pkg::ST_SETUP
                                                                  : tmp_pkg::ST_PHASE;
                end
            end
            tmp_pkg::ST_SETUP:  state_next = tmp_pkg::ST_MUL_VV;
            tmp_pkg::ST_MUL_VV: state_next = tmp_pkg::ST_MUL_DA;
            tmp_pkg::ST_MUL_DA: state_next = tmp_pkg::ST_CMP;
            tmp_pkg::ST_CMP:    state_next = tmp_pkg::ST_DIV1;
            tmp_pkg::ST_DIV1: begin
                if (iter_stat.done) begin
                    state_next = tri_reg ? tmp_pkg::ST_SQRT : tmp_pkg::ST_DIV2;
                end
            end
            tmp_pkg::ST_SQRT: begin
                if (iter_stat.done) begin
                    state_next = tmp_pkg::ST_MUL_PK;
                end
            end
            tmp_pkg::ST_MUL_PK: state_next = tmp_pkg::ST_PEAK;
            tmp_pkg::ST_PEAK:   state_next = tmp_pkg::ST_PHASE;
            tmp_pkg::ST_DIV2: begin
                if (iter_stat.done) begin
                    state_next = tmp_pkg::ST_DIV3;
                end
            end
            tmp_pkg::ST_DIV3: begin
                if (iter_stat.done) begin
                    state_next = tmp_pkg::ST_PHASE;
                end
            end
            tmp_pkg::ST_PHASE: state_next = tmp_pkg::ST_MA;
            tmp_pkg::ST_MA:    state_next = tmp_pkg::ST_MB;
            tmp_pkg::ST_MB:    state_next = tmp_pkg::ST_MC;
            tmp_pkg::ST_MC:    state_next = tmp_pkg::ST_MD;
            tmp_pkg::ST_MD:    state_next = tmp_pkg::ST_ME;
            tmp_pkg::ST_ME:    state_next = tmp_pkg::ST_MF;
            tmp_pkg::ST_MF:    state_next = tmp_pkg::ST_COMB;
            tmp_pkg::ST_COMB:  state_next = tmp_pkg::ST_OUT;
            tmp_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = tmp_pkg::ST_IDLE;
                end
            end
            default: state_next = tmp_pkg::ST_IDLE;
        endcase
    end

    // Unit controls.
    always_comb begin
        mul_a           = 32'd0;
        mul_b           = 32'd0;
        iter_ctrl.start = 1'b0;
        iter_ctrl.sqrt_mode = 1'b0;
        iter_dividend   = 64'd0;
        iter_divisor    = {1'b0, al_nz};
        case (state_reg)
            tmp_pkg::ST_MUL_VV: begin
                mul_a = {1'b0, vl_nz};
                mul_b = {1'b0, vl_nz};
            end
            tmp_pkg::ST_MUL_DA: begin
                mul_a = dist_reg;
                mul_b = {1'b0, al_nz};
            end
            tmp_pkg::ST_CMP: begin
                iter_ctrl.start = 1'b1;
                iter_dividend   = tri_now ? {dist_reg, 32'd0} : vv_reg;
            end
            tmp_pkg::ST_DIV1: begin
                if (iter_stat.done) begin
                    iter_ctrl.start     = 1'b1;
                    iter_ctrl.sqrt_mode = tri_reg;
                    iter_dividend = tri_reg ? iter_result : {17'd0, vl_nz, 16'd0};
                end
            end
            tmp_pkg::ST_DIV2: begin
                if (iter_stat.done) begin
                    iter_ctrl.start = 1'b1;
                    iter_dividend   = {16'd0, dist_rem_reg, 16'd0};
                    iter_divisor    = {1'b0, vl_nz};
                end
            end
            tmp_pkg::ST_MUL_PK: begin
                mul_a = {1'b0, al_nz};
                mul_b = ramp_reg;
            end
            tmp_pkg::ST_MA: begin
                mul_a = {1'b0, al_nz};
                mul_b = x_reg;
            end
            tmp_pkg::ST_MB: begin
                mul_a = peak_reg;
                mul_b = ramp_reg;
            end
            tmp_pkg::ST_MC: begin
                mul_a = peak_reg;
                mul_b = cruise_reg;
            end
            tmp_pkg::ST_MD: begin
                mul_a = peak_reg;
                mul_b = y_reg;
            end
            tmp_pkg::ST_ME: begin
                mul_a = vel_reg;
                mul_b = x_reg;
            end
            default: begin
                mul_a = 32'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tmp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            vel_lim_reg <= 31'd65536;
            acc_lim_reg <= 31'd65536;
            tick_reg    <= 31'd655;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tmp_pkg::CFG_VEL_LIMIT: vel_lim_reg <= cfg_data[30:0];
                    tmp_pkg::CFG_ACC_LIMIT: acc_lim_reg <= cfg_data[30:0];
                    tmp_pkg::CFG_TICK:      tick_reg    <= cfg_data[30:0];
                    default:                tick_reg    <= tick_reg;
                endcase
            end
            if (state_reg == tmp_pkg::ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_point_reg <= 32'sd0;
            dist_reg        <= 32'd0;
            down_reg        <= 1'b0;
            ramp_reg        <= 32'd65536;
            cruise_reg      <= 32'd0;
            peak_reg        <= 32'd0;
            elapsed_reg     <= 32'd0;
        end else begin
            case (state_reg)
                tmp_pkg::ST_SETUP: begin
                    start_point_reg <= in_reg.present_position;
                    down_reg        <= delta[32];
                    dist_reg        <= mag[32] ? 32'hFFFF_FFFF : mag[31:0];
                end
                tmp_pkg::ST_SQRT: begin
                    if (iter_stat.done) begin
                        ramp_reg   <= iter_result[31:0];
                        cruise_reg <= 32'd0;
                    end
                end
                tmp_pkg::ST_PEAK: begin
                    peak_reg    <= (mul_prod[63:48] != 16'd0) ? 32'hFFFF_FFFF
                                                              : mul_prod[47:16];
                    elapsed_reg <= 32'd0;
                end
                tmp_pkg::ST_DIV2: begin
                    if (iter_stat.done) begin
                        ramp_reg <= (iter_result[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                                  : iter_result[31:0];
                    end
                end
                tmp_pkg::ST_DIV3: begin
                    if (iter_stat.done) begin
                        cruise_reg  <= (iter_result[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                                     : iter_result[31:0];
                        peak_reg    <= {1'b0, vl_nz};
                        elapsed_reg <= 32'd0;
                    end
                end
                tmp_pkg::ST_OUT: begin
                    if ((!m_valid_reg || m_ready) && in_reg.op == tmp_pkg::OP_TICK) begin
                        elapsed_reg <= el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
                    end
                end
                default: begin
                    elapsed_reg <= elapsed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        case (state_reg)
            tmp_pkg::ST_MUL_DA: vv_reg <= mul_prod;
            tmp_pkg::ST_CMP:    tri_reg <= tri_now;
            tmp_pkg::ST_DIV1: begin
                if (iter_stat.done && !tri_reg) begin
                    dist_rem_reg <= dist_reg - iter_result[31:0];
                end
            end
            tmp_pkg::ST_PHASE: begin
                done_flag_reg <= ({2'b00, elapsed_reg} > total);
                if (elapsed_reg < ramp_reg) begin
                    phase_reg <= tmp_pkg::PH_ACCEL;
                    x_reg     <= elapsed_reg;
                    y_reg     <= t_dec;
                end else if ({1'b0, elapsed_reg} < rc_sum) begin
                    phase_reg <= tmp_pkg::PH_CRUISE;
                    x_reg     <= t_dec;
                    y_reg     <= e_r;
                end else if ({2'b00, elapsed_reg} < total) begin
                    phase_reg <= tmp_pkg::PH_DECEL;
                    x_reg     <= t_dec;
                    y_reg     <= t_dec;
                end else begin
                    phase_reg <= tmp_pkg::PH_DONE;
                    x_reg     <= t_dec;
                    y_reg     <= t_dec;
                end
            end
            tmp_pkg::ST_MB: vel_reg   <= vel_min;
            tmp_pkg::ST_MC: term0_reg <= mul_prod[63:17];
            tmp_pkg::ST_MD: term1_reg <= mul_prod[63:16];
            tmp_pkg::ST_ME: term2_reg <= mul_prod[63:16];
            tmp_pkg::ST_MF: s_reg     <= mul_prod[63:17];
            tmp_pkg::ST_COMB: begin
                pos_reg <= p_fin;
                spd_reg <= v_fin;
            end
            tmp_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    if (pos_ext[33:31] == 3'b000 || pos_ext[33:31] == 3'b111) begin
                        out_reg.position_setpoint <= pos_ext[31:0];
                    end else begin
                        out_reg.position_setpoint <= pos_ext[33] ? 32'sh8000_0000
                                                                 : 32'sh7FFF_FFFF;
                    end
                    if (vel_ext[32] == vel_ext[31]) begin
                        out_reg.velocity_setpoint <= vel_ext[31:0];
                    end else begin
                        out_reg.velocity_setpoint <= vel_ext[32] ? 32'sh8000_0000
                                                                 : 32'sh7FFF_FFFF;
                    end
                    out_reg.accel_setpoint <= acc_val;
                    out_reg.profile_done   <= done_flag_reg;
                end
            end
            default: begin
                tri_reg <= tri_reg;
            end
        endcase
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before the transaction finished");

    a_done_is_at_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.profile_done |->
            m_data.velocity_setpoint == 32'sd0 && m_data.accel_setpoint == 32'sd0)
        else $error("finished profile reports motion");

    a_time_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tmp_pkg::ST_OUT && in_reg.op == tmp_pkg::OP_TICK
            |=> elapsed_reg >= $past(elapsed_reg))
        else $error("elapsed time went backward on a tick");

endmodule
